[rtl/svpd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svpd_pkg
// Shared constants for the stereo level tracker: widths, register map and
// parameter defaults.
// ----------------------------------------------------------------------------
package svpd_pkg;

  // parameter defaults
  localparam int LEVEL_FRAC_BITS_DEF  = 8;
  localparam int DECAY_TABLE_SIZE_DEF = 256;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int HALF_W    = 16;
  localparam int DELTA_W   = 24;
  localparam int DECAY_W   = 17;
  localparam int DECAY_SH  = 16;
  localparam int IP_W      = 5;
  localparam logic [IP_W-1:0] IP_LIMIT = 5'd17;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register indexes (byte address 4*i)
  localparam logic [0:0] REG_HALF_LIFE    = 1'b0;
  localparam logic [0:0] REG_LEVEL_THRESH = 1'b1;

  // register reset values
  localparam logic [HALF_W-1:0]  HALF_LIFE_RST    = 16'd800;
  localparam logic [DELTA_W-1:0] LEVEL_THRESH_RST = 24'd512;

  // fixed point constants for building the decay table
  localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6A;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

endpackage : svpd_pkg
`default_nettype wire

[rtl/stereo_vu_peak_decay_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_vu_peak_decay_top
// Stereo VU level tracker with peak hold and exponential decay.
// ----------------------------------------------------------------------------
// Each input word carries a frame interval and the left and right peaks; one
// output word with both smoothed integer levels follows for every input word.
// The block takes one word at a time and is not ready while it works on it.
// After accept the word passes through the restoring divider, which
// produces one quotient bit a cycle; the same subtractor then splits the
// ratio into the integer part i (0 to 17) of interval/half_life and the
// fraction, one step a cycle; the one multiplier, shared over both
// channels, then scales each level, and the output register may wait on
// m_tready. Configuration is written over the APB port while the block is
// idle; the user is bound to this, the block itself does not enforce it. A
// zero half-life write is ignored. No clearing pass after reset.
// ----------------------------------------------------------------------------
module stereo_vu_peak_decay_top
  import svpd_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS  = LEVEL_FRAC_BITS_DEF,
  parameter int DECAY_TABLE_SIZE = DECAY_TABLE_SIZE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [47:0]           s_tdata,   // interval_q4, peak_left, peak_right
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [31:0]                m_tdata,   // level_left, level_right
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int LEVEL_BITS = SAMPLE_W + LEVEL_FRAC_BITS;
  localparam int TBL_W      = $clog2(DECAY_TABLE_SIZE);
  localparam int NUM_W      = SAMPLE_W + TBL_W;
  localparam int DEN_W      = HALF_W + 4;
  localparam int SUB_W      = (NUM_W > DEN_W + 1) ? NUM_W : DEN_W + 1;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int PROD_W     = LEVEL_BITS + DECAY_W;
  localparam int CMP_W      = (LEVEL_BITS > DELTA_W) ? LEVEL_BITS : DELTA_W;

  typedef logic [DECAY_W-1:0] lut_t [DECAY_TABLE_SIZE];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SPLIT,
    ST_MUL,
    ST_TRACK,
    ST_OUT
  } state_t;

  // (a * b) >> 62, kept to 64 bits
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // round(65536 * 2^(-f/size)) by a series for exp(-x), x = f*ln2/size
  function automatic logic [DECAY_W-1:0] decay_entry(logic [63:0] f);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rnd;
    x    = (LN2_Q62 / DECAY_TABLE_SIZE) * f
         + ((LN2_Q62 % DECAY_TABLE_SIZE) * f) / DECAY_TABLE_SIZE;
    sum  = ONE_Q62;
    term = ONE_Q62;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term = mul_q62(term, x) / 64'(n);
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    rnd = (sum + (64'd1 << 45)) >> 46;
    return rnd[DECAY_W-1:0];
  endfunction

  function automatic lut_t build_lut();
    lut_t t;
    for (int k = 0; k < DECAY_TABLE_SIZE; k++) begin
      t[k] = decay_entry(64'(k));
    end
    return t;
  endfunction

  localparam lut_t DECAY_LUT = build_lut();

  state_t                   state;
  logic [HALF_W-1:0]        half_life;
  logic [DELTA_W-1:0]       level_thresh;
  logic [LEVEL_BITS-1:0]    smoothed_left;
  logic [LEVEL_BITS-1:0]    smoothed_right;
  logic [SAMPLE_W-1:0]      peak_left;
  logic [SAMPLE_W-1:0]      peak_right;
  logic [NUM_W-1:0]         quo;
  logic [DEN_W-1:0]         rem;
  logic [DEN_W-1:0]         den;
  logic [CNT_W-1:0]         step_cnt;
  logic [IP_W-1:0]          ip;
  logic [DECAY_W-1:0]       decay;
  logic                     chan;
  logic [PROD_W-1:0]        prod;

  logic [SAMPLE_W-1:0]      iv;
  logic                     in_word;
  logic                     cfg_wr;
  logic [0:0]               cfg_idx;
  logic [SUB_W-1:0]         sub_a;
  logic [SUB_W-1:0]         sub_b;
  logic [SUB_W:0]           sub_diff;
  logic                     sub_ge;
  logic [LEVEL_BITS-1:0]    lvl;
  logic [LEVEL_BITS-1:0]    cur_dec;
  logic [LEVEL_BITS-1:0]    pk_ext;
  logic [LEVEL_BITS-1:0]    cur;
  logic [LEVEL_BITS-1:0]    diff;
  logic                     upd;

  // handshakes
  assign s_tready = (state == ST_IDLE);
  assign in_word  = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[2];

  // zero interval counts as 16 ms
  assign iv = (s_tdata[15:0] == '0) ? SAMPLE_W'(256) : s_tdata[15:0];

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_HALF_LIFE:    prdata = CFG_DATA_W'(half_life);
      REG_LEVEL_THRESH: prdata = CFG_DATA_W'(level_thresh);
      default:          prdata = '0;
    endcase
  end

  // shared subtractor: divider step, or ratio minus table size
  always_comb begin
    case (state)
      ST_SPLIT: begin
        sub_a = SUB_W'(quo);
        sub_b = SUB_W'(DECAY_TABLE_SIZE);
      end
      default: begin
        sub_a = SUB_W'({rem, quo[NUM_W-1]});
        sub_b = SUB_W'(den);
      end
    endcase
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = !sub_diff[SUB_W];
  end

  // decayed level against peak, and the update test
  always_comb begin
    lvl     = chan ? smoothed_right : smoothed_left;
    cur_dec = prod[DECAY_SH +: LEVEL_BITS];
    pk_ext  = LEVEL_BITS'(chan ? peak_right : peak_left) << LEVEL_FRAC_BITS;
    cur     = (pk_ext > cur_dec) ? pk_ext : cur_dec;
    diff    = (cur > lvl) ? (cur - lvl) : (lvl - cur);
    upd     = CMP_W'(diff) > CMP_W'(level_thresh);
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      half_life      <= HALF_LIFE_RST;
      level_thresh   <= LEVEL_THRESH_RST;
      smoothed_left  <= '0;
      smoothed_right <= '0;
    end else begin
      // configuration writes
      if (cfg_wr) begin
        case (cfg_idx)
          REG_HALF_LIFE: begin
            if (pwdata[HALF_W-1:0] != '0) half_life <= pwdata[HALF_W-1:0];
          end
          REG_LEVEL_THRESH: level_thresh <= pwdata[DELTA_W-1:0];
          default: ;
        endcase
      end

      // drop valid once taken, unless a new word is loaded below
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_word) begin
            quo        <= NUM_W'(iv) * NUM_W'(DECAY_TABLE_SIZE);
            rem        <= '0;
            den        <= {half_life, 4'b0000};
            step_cnt   <= '0;
            peak_left  <= s_tdata[31:16];
            peak_right <= s_tdata[47:32];
            state      <= ST_DIV;
          end
        end
        // one quotient bit a cycle
        ST_DIV: begin
          if (sub_ge) begin
            rem <= sub_diff[DEN_W-1:0];
          end else begin
            rem <= {rem[DEN_W-2:0], quo[NUM_W-1]};
          end
          quo      <= {quo[NUM_W-2:0], sub_ge};
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == CNT_W'(NUM_W - 1)) begin
            ip    <= '0;
            state <= ST_SPLIT;
          end
        end
        // integer part by repeated subtraction, fraction is what remains
        ST_SPLIT: begin
          if (sub_ge && (ip != IP_LIMIT)) begin
            quo <= sub_diff[NUM_W-1:0];
            ip  <= ip + 1'b1;
          end else begin
            if (ip == IP_LIMIT) begin
              decay <= '0;
            end else begin
              decay <= DECAY_LUT[quo[TBL_W-1:0]] >> ip;
            end
            chan  <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(lvl) * PROD_W'(decay);
          state <= ST_TRACK;
        end
        ST_TRACK: begin
          if (upd) begin
            if (chan) begin
              smoothed_right <= cur;
            end else begin
              smoothed_left <= cur;
            end
          end
          if (chan) begin
            state <= ST_OUT;
          end else begin
            chan  <= 1'b1;
            state <= ST_MUL;
          end
        end
        // wait for the output register to free up
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {smoothed_right[LEVEL_FRAC_BITS +: SAMPLE_W],
                         smoothed_left[LEVEL_FRAC_BITS +: SAMPLE_W]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule : stereo_vu_peak_decay_top
`default_nettype wire
